// ===== sv/snc_pkg.sv =====
// ----------------------------------------------------------------------------
// snc_pkg
// shared constants and types for the 8.3 short-name canonicalizer
// ----------------------------------------------------------------------------
`default_nettype none

package snc_pkg;

  localparam int BASE_CHARS = 8;
  localparam int EXT_CHARS  = 3;

  localparam int BASE_SLOTS = 8;
  localparam int EXT_SLOTS  = 3;

  localparam int BASE_COUNT_W = $clog2(BASE_SLOTS + 1);
  localparam int EXT_COUNT_W  = $clog2(EXT_SLOTS + 1);

  typedef logic [7:0] char_t;
  typedef logic [BASE_COUNT_W-1:0] base_count_t;
  typedef logic [EXT_COUNT_W-1:0] ext_count_t;

  localparam char_t NUL_CHAR        = 8'h00;
  localparam char_t SPACE_CHAR      = 8'h20;
  localparam char_t DOT_CHAR        = 8'h2e;
  localparam char_t UNDERSCORE_CHAR = 8'h5f;
  localparam char_t HYPHEN_CHAR     = 8'h2d;
  localparam char_t CASE_OFFSET     = 8'h20;
  localparam char_t LOWER_A         = 8'h61;
  localparam char_t LOWER_Z         = 8'h7a;
  localparam char_t UPPER_A         = 8'h41;
  localparam char_t UPPER_Z         = 8'h5a;
  localparam char_t DIGIT_0         = 8'h30;
  localparam char_t DIGIT_9         = 8'h39;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_INVALID = 1'b1;

  localparam logic [8*BASE_SLOTS-1:0] BASE_BLANK = {BASE_SLOTS{SPACE_CHAR}};
  localparam logic [8*EXT_SLOTS-1:0]  EXT_BLANK  = {EXT_SLOTS{SPACE_CHAR}};

  function automatic char_t fold_case(input char_t c);
    fold_case = (c >= LOWER_A && c <= LOWER_Z) ? char_t'(c - CASE_OFFSET) : c;
  endfunction

  function automatic logic char_ok(input char_t c);
    char_ok = (c >= UPPER_A && c <= UPPER_Z) || (c >= DIGIT_0 && c <= DIGIT_9) ||
              c == UNDERSCORE_CHAR || c == HYPHEN_CHAR;
  endfunction

endpackage

`default_nettype wire

// ===== sv/short_name_canonicalizer.sv =====
// ----------------------------------------------------------------------------
// short_name_canonicalizer
// builds an upper-case, space-padded 8.3 short name from a byte stream
// ----------------------------------------------------------------------------
// One name byte is taken per beat and a new byte can be accepted every clock
// cycle, unless a closing byte waits for the result register. Each byte first
// lands in an input register, from which it updates the name state
// (base/extension counts, dot and error flags, the eleven stored characters).
// A zero byte closes the name and loads the result register in that same
// cycle; its result passes the input register, then the result register.
// Only a closing byte waits for a full result register to drain; other bytes
// keep flowing while a result is held. Invalid names report all-space fields.
// ----------------------------------------------------------------------------
`default_nettype none

module short_name_canonicalizer
  import snc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        name_valid,
  output logic             name_ready,
  input  wire logic [7:0]  name_byte,
  output logic             result_valid,
  input  wire logic        result_ready,
  output logic             status,
  output logic [63:0]      base_name,
  output logic [23:0]      extension_name
);

  // input register
  logic  byte_valid;
  char_t byte_q;

  // name state
  char_t       base_store [BASE_SLOTS];
  char_t       ext_store  [EXT_SLOTS];
  base_count_t base_count;
  ext_count_t  ext_count;
  logic        in_ext;
  logic        failed;

  char_t       base_store_next [BASE_SLOTS];
  char_t       ext_store_next  [EXT_SLOTS];
  base_count_t base_count_next;
  ext_count_t  ext_count_next;
  logic        in_ext_next;
  logic        failed_next;

  logic        is_term;
  logic        fire;
  logic        bad;
  char_t       folded;
  logic [63:0] base_pack;
  logic [23:0] ext_pack;

  assign is_term    = (byte_q == NUL_CHAR);
  assign fire       = byte_valid && (!is_term || !result_valid || result_ready);
  assign name_ready = !byte_valid || fire;
  assign folded     = fold_case(byte_q);
  assign bad        = failed || (base_count == '0 && !in_ext);

  always_comb begin
    for (int i = 0; i < BASE_SLOTS; i++) begin
      base_pack[8*i +: 8] = base_store[i];
    end
    for (int i = 0; i < EXT_SLOTS; i++) begin
      ext_pack[8*i +: 8] = ext_store[i];
    end
  end

  always_comb begin
    base_store_next = base_store;
    ext_store_next  = ext_store;
    base_count_next = base_count;
    ext_count_next  = ext_count;
    in_ext_next     = in_ext;
    failed_next     = failed;
    if (fire) begin
      if (is_term) begin
        for (int i = 0; i < BASE_SLOTS; i++) begin
          base_store_next[i] = SPACE_CHAR;
        end
        for (int i = 0; i < EXT_SLOTS; i++) begin
          ext_store_next[i] = SPACE_CHAR;
        end
        base_count_next = '0;
        ext_count_next  = '0;
        in_ext_next     = 1'b0;
        failed_next     = 1'b0;
      end else if (!failed) begin
        if (byte_q == DOT_CHAR) begin
          if (in_ext || base_count == '0) begin
            failed_next = 1'b1;
          end else begin
            in_ext_next = 1'b1;
          end
        end else if (!char_ok(folded)) begin
          failed_next = 1'b1;
        end else if (!in_ext) begin
          if (base_count >= BASE_COUNT_W'(BASE_CHARS)) begin
            failed_next = 1'b1;
          end else begin
            for (int i = 0; i < BASE_SLOTS; i++) begin
              if (base_count == BASE_COUNT_W'(i)) begin
                base_store_next[i] = folded;
              end
            end
            base_count_next = BASE_COUNT_W'(base_count + 1'b1);
          end
        end else begin
          if (ext_count >= EXT_COUNT_W'(EXT_CHARS)) begin
            failed_next = 1'b1;
          end else begin
            for (int i = 0; i < EXT_SLOTS; i++) begin
              if (ext_count == EXT_COUNT_W'(i)) begin
                ext_store_next[i] = folded;
              end
            end
            ext_count_next = EXT_COUNT_W'(ext_count + 1'b1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (name_valid && name_ready) begin
      byte_valid <= 1'b1;
    end else if (fire) begin
      byte_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (name_valid && name_ready) begin
      byte_q <= name_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < BASE_SLOTS; i++) begin
        base_store[i] <= SPACE_CHAR;
      end
      for (int i = 0; i < EXT_SLOTS; i++) begin
        ext_store[i] <= SPACE_CHAR;
      end
      base_count <= '0;
      ext_count  <= '0;
      in_ext     <= 1'b0;
      failed     <= 1'b0;
    end else begin
      base_store <= base_store_next;
      ext_store  <= ext_store_next;
      base_count <= base_count_next;
      ext_count  <= ext_count_next;
      in_ext     <= in_ext_next;
      failed     <= failed_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (fire && is_term) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && is_term) begin
      status         <= bad ? STATUS_INVALID : STATUS_OK;
      base_name      <= bad ? BASE_BLANK : base_pack;
      extension_name <= bad ? EXT_BLANK : ext_pack;
    end
  end

  a_base_bound: assert property (@(posedge clk) disable iff (rst)
    base_count <= BASE_COUNT_W'(BASE_CHARS))
    else $error("base count beyond limit");

  a_ext_only_after_dot: assert property (@(posedge clk) disable iff (rst)
    !in_ext |-> ext_count == '0)
    else $error("extension chars without a dot");

  a_clear_after_term: assert property (@(posedge clk) disable iff (rst)
    fire && is_term |=> base_count == '0 && !in_ext && !failed && result_valid)
    else $error("state not cleared after terminator");

  a_invalid_blank: assert property (@(posedge clk) disable iff (rst)
    result_valid && status == STATUS_INVALID |->
      base_name == BASE_BLANK && extension_name == EXT_BLANK)
    else $error("invalid result carries characters");

  a_term_waits: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready && byte_valid && is_term |-> !fire)
    else $error("terminator overwrote held result");

endmodule

`default_nettype wire
